// ===== rtl/core/mvsm_pkg.sv =====
// Shared widths, mode codes and sample type for the multi-voice sample mixer.
// Depends on nothing; every other file of the mixer refers to it by scoped names.
`default_nettype none

package mvsm_pkg;

  localparam int unsigned SAMPLE_W  = 16;  // one PCM word
  localparam int unsigned ADDR_IN_W = 16;  // address field and voice start
  localparam int unsigned LEN_W     = 17;  // sound length and play position
  localparam int unsigned OP_W      = 18;  // start plus position plus one
  localparam int unsigned MODE_W    = 3;
  localparam int unsigned SEL_W     = 3;

  localparam logic [MODE_W-1:0] MODE_LOAD     = 3'd0;
  localparam logic [MODE_W-1:0] MODE_START    = 3'd1;
  localparam logic [MODE_W-1:0] MODE_STOP     = 3'd2;
  localparam logic [MODE_W-1:0] MODE_STOP_ALL = 3'd3;
  localparam logic [MODE_W-1:0] MODE_MIX      = 3'd4;

  typedef logic signed [SAMPLE_W-1:0] sample_t;

endpackage

`default_nettype wire

// ===== rtl/core/multi_voice_sample_mixer.sv =====
// Multi-voice stereo PCM playback mixer over a shared sample memory.
// A request is accepted at a rising edge with start high and busy low; mode_i
// picks load word, start sound, stop voice, stop all, or mix one stereo frame.
// Every request yields exactly one result, shown for one cycle with done_o high.
// The receiver cannot stall; results must be taken in the cycle they appear.
// Start, stop, stop all and unused modes answer in the cycle after acceptance.
// Every memory address passes through one shared modulo unit, a plain mask
// when SAMPLE_WORDS is a power of two (default), else restoring subtraction in
// 19 - clog2(SAMPLE_WORDS) steps but never below zero. A load answers as its
// word is written, once the unit has reduced its address.
// A mix walks the voices one after another through that unit and the single
// memory read port, skipping silent voices, reducing and reading the left then
// the right word of each active voice, and scales both sums after the last.
// busy stays high during a load or mix until its result is shown; the next request may be taken
// in the same cycle as done_o. Reset stops all voices and clears positions;
// sample memory contents are not cleared and must be loaded before use.
`default_nettype none

module multi_voice_sample_mixer #(
  parameter int unsigned VOICES       = 8,
  parameter int unsigned SAMPLE_WORDS = 65536
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              start,
  output logic                                   busy,
  input  wire logic [mvsm_pkg::MODE_W-1:0]       mode_i,
  input  wire logic [mvsm_pkg::ADDR_IN_W-1:0]    sample_address_i,
  input  wire mvsm_pkg::sample_t                 sample_value_i,
  input  wire logic [mvsm_pkg::LEN_W-1:0]        sound_length_i,
  input  wire logic                              loop_flag_i,
  input  wire logic [mvsm_pkg::SEL_W-1:0]        voice_select_i,
  output logic                                   done_o,
  output mvsm_pkg::sample_t                      left_sample_o,
  output mvsm_pkg::sample_t                      right_sample_o,
  output logic [2:0]                             voice_index_o,
  output logic                                   voice_found_o
);

  localparam int unsigned AW    = $clog2(SAMPLE_WORDS);
  localparam int unsigned VIW   = (VOICES > 1) ? $clog2(VOICES) : 1;
  localparam int unsigned VCW   = $clog2(VOICES + 1);
  localparam int unsigned ACC_W = mvsm_pkg::SAMPLE_W + 1 + $clog2(VOICES);
  localparam int unsigned OP_W  = mvsm_pkg::OP_W;
  localparam int unsigned LEN_W = mvsm_pkg::LEN_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOAD,
    S_MIX_VOICE,
    S_MIX_LADDR,
    S_MIX_RADDR,
    S_MIX_RDATA
  } state_e;

  state_e state_q;

  logic                                done_q;
  mvsm_pkg::sample_t                   left_q;
  mvsm_pkg::sample_t                   right_q;
  logic [2:0]                          vidx_q;
  logic                                found_q;
  mvsm_pkg::sample_t                   wdata_q;
  logic signed [ACC_W-1:0]             acc_l_q;
  logic signed [ACC_W-1:0]             acc_r_q;
  logic [VCW-1:0]                      vc_q;

  logic [VOICES-1:0]                   active_q;
  logic [VOICES-1:0]                   vloop_q;
  logic [LEN_W-1:0]                    vpos_q   [VOICES];
  logic [LEN_W-1:0]                    vlen_q   [VOICES];
  logic [mvsm_pkg::ADDR_IN_W-1:0]      vstart_q [VOICES];

  logic [VIW-1:0]                      vidx;
  logic [VIW-1:0]                      sel_idx;
  logic                                sel_ok;
  logic [VIW-1:0]                      free_idx;
  logic                                free_found;
  logic                                vc_end;

  logic [LEN_W-1:0]                    pos_cur;
  logic [LEN_W-1:0]                    len_cur;
  logic [OP_W-1:0]                     addr_l;
  logic [OP_W-1:0]                     addr_r;
  logic [OP_W-1:0]                     pos_adv;
  logic [OP_W-1:0]                     pos_wrap;
  logic [LEN_W-1:0]                    pos_next;
  logic                                stays_active;

  logic                                red_start;
  logic [OP_W-1:0]                     red_operand;
  logic                                red_done;
  logic [AW-1:0]                       red_addr;

  logic                                ram_wr_en;
  logic                                ram_rd_en;
  mvsm_pkg::sample_t                   ram_rd_data;
  logic signed [ACC_W-1:0]             rd_ext;

  mvsm_pkg::sample_t                   left_scaled;
  mvsm_pkg::sample_t                   right_scaled;

  assign busy           = (state_q != S_IDLE);
  assign done_o         = done_q;
  assign left_sample_o  = left_q;
  assign right_sample_o = right_q;
  assign voice_index_o  = vidx_q;
  assign voice_found_o  = found_q;

  assign vidx    = vc_q[VIW-1:0];
  assign vc_end  = (vc_q == VCW'(VOICES));
  assign sel_idx = VIW'(voice_select_i);
  assign sel_ok  = (32'(voice_select_i) < VOICES);

  // Lowest free voice wins.
  always_comb begin
    free_idx   = '0;
    free_found = 1'b0;
    for (int i = VOICES - 1; i >= 0; i--) begin
      if (!active_q[i]) begin
        free_idx   = VIW'(i);
        free_found = 1'b1;
      end
    end
  end

  assign pos_cur = vpos_q[vidx];
  assign len_cur = vlen_q[vidx];
  assign addr_l  = OP_W'(vstart_q[vidx]) + OP_W'(pos_cur);
  assign addr_r  = addr_l + OP_W'(1);

  // End of sound: a looping voice wraps by its length, and falls back to zero
  // when the length is shorter than one frame; a one-shot voice stops.
  always_comb begin
    pos_adv      = OP_W'(pos_cur) + OP_W'(2);
    pos_wrap     = pos_adv - OP_W'(len_cur);
    pos_next     = pos_adv[LEN_W-1:0];
    stays_active = 1'b1;
    if (pos_adv >= OP_W'(len_cur)) begin
      if (vloop_q[vidx]) begin
        pos_next = (pos_wrap >= OP_W'(len_cur)) ? '0 : pos_wrap[LEN_W-1:0];
      end else begin
        stays_active = 1'b0;
        pos_next     = '0;
      end
    end
  end

  always_comb begin
    red_start   = 1'b0;
    red_operand = OP_W'(sample_address_i);
    unique case (state_q)
      S_IDLE: begin
        red_start = start && (mode_i == mvsm_pkg::MODE_LOAD);
      end
      S_MIX_VOICE: begin
        red_start   = !vc_end && active_q[vidx];
        red_operand = addr_l;
      end
      S_MIX_LADDR: begin
        red_start   = red_done;
        red_operand = addr_r;
      end
      default: begin
      end
    endcase
  end

  assign ram_wr_en = (state_q == S_LOAD) && red_done;
  assign ram_rd_en = ((state_q == S_MIX_LADDR) || (state_q == S_MIX_RADDR)) && red_done;
  assign rd_ext    = ACC_W'(ram_rd_data);

  mvsm_addr_mod #(
    .SAMPLE_WORDS(SAMPLE_WORDS)
  ) u_addr_mod (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (red_start),
    .operand_i (red_operand),
    .done_o    (red_done),
    .addr_o    (red_addr)
  );

  mvsm_sample_ram #(
    .DEPTH(SAMPLE_WORDS)
  ) u_sample_ram (
    .clk_i     (clk_i),
    .wr_en_i   (ram_wr_en),
    .wr_addr_i (red_addr),
    .wr_data_i (wdata_q),
    .rd_en_i   (ram_rd_en),
    .rd_addr_i (red_addr),
    .rd_data_o (ram_rd_data)
  );

  mvsm_out_scale #(
    .ACC_W(ACC_W)
  ) u_scale_l (
    .sum_i    (acc_l_q),
    .sample_o (left_scaled)
  );

  mvsm_out_scale #(
    .ACC_W(ACC_W)
  ) u_scale_r (
    .sum_i    (acc_r_q),
    .sample_o (right_scaled)
  );

  // Start address and length of a voice are only read while it is active.
  always_ff @(posedge clk_i) begin
    if ((state_q == S_IDLE) && start && (mode_i == mvsm_pkg::MODE_START) && free_found) begin
      vstart_q[free_idx] <= sample_address_i;
      vlen_q[free_idx]   <= sound_length_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      done_q   <= 1'b0;
      left_q   <= '0;
      right_q  <= '0;
      vidx_q   <= '0;
      found_q  <= 1'b0;
      wdata_q  <= '0;
      acc_l_q  <= '0;
      acc_r_q  <= '0;
      vc_q     <= '0;
      active_q <= '0;
      vloop_q  <= '0;
      for (int i = 0; i < VOICES; i++) begin
        vpos_q[i] <= '0;
      end
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (start) begin
            left_q  <= '0;
            right_q <= '0;
            vidx_q  <= '0;
            found_q <= 1'b0;
            unique case (mode_i)
              mvsm_pkg::MODE_LOAD: begin
                wdata_q <= sample_value_i;
                state_q <= S_LOAD;
              end
              mvsm_pkg::MODE_START: begin
                if (free_found) begin
                  active_q[free_idx] <= 1'b1;
                  vpos_q[free_idx]   <= '0;
                  vloop_q[free_idx]  <= loop_flag_i;
                  vidx_q             <= 3'(free_idx);
                  found_q            <= 1'b1;
                end
                done_q <= 1'b1;
              end
              mvsm_pkg::MODE_STOP: begin
                if (sel_ok) begin
                  active_q[sel_idx] <= 1'b0;
                end
                done_q <= 1'b1;
              end
              mvsm_pkg::MODE_STOP_ALL: begin
                active_q <= '0;
                done_q   <= 1'b1;
              end
              mvsm_pkg::MODE_MIX: begin
                acc_l_q <= '0;
                acc_r_q <= '0;
                vc_q    <= '0;
                state_q <= S_MIX_VOICE;
              end
              default: begin
                done_q <= 1'b1;
              end
            endcase
          end
        end
        S_LOAD: begin
          if (red_done) begin
            done_q  <= 1'b1;
            state_q <= S_IDLE;
          end
        end
        S_MIX_VOICE: begin
          if (vc_end) begin
            left_q  <= left_scaled;
            right_q <= right_scaled;
            done_q  <= 1'b1;
            state_q <= S_IDLE;
          end else if (active_q[vidx]) begin
            state_q <= S_MIX_LADDR;
          end else begin
            vc_q <= vc_q + VCW'(1);
          end
        end
        S_MIX_LADDR: begin
          if (red_done) begin
            state_q <= S_MIX_RADDR;
          end
        end
        S_MIX_RADDR: begin
          // The left word was read the cycle this state was entered and holds.
          if (red_done) begin
            acc_l_q <= acc_l_q + rd_ext;
            state_q <= S_MIX_RDATA;
          end
        end
        S_MIX_RDATA: begin
          acc_r_q        <= acc_r_q + rd_ext;
          vpos_q[vidx]   <= pos_next;
          active_q[vidx] <= stays_active;
          vc_q           <= vc_q + VCW'(1);
          state_q        <= S_MIX_VOICE;
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/mvsm_addr_mod.sv =====
// Shared address reduction unit: operand modulo SAMPLE_WORDS by restoring
// conditional subtraction, one step per cycle. Depends on mvsm_pkg.
`default_nettype none

module mvsm_addr_mod #(
  parameter int unsigned SAMPLE_WORDS = 65536
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       start_i,
  input  wire logic [mvsm_pkg::OP_W-1:0]  operand_i,
  output logic                            done_o,
  output logic [$clog2(SAMPLE_WORDS)-1:0] addr_o
);

  localparam int unsigned AW    = $clog2(SAMPLE_WORDS);
  localparam bit          POW2  = (SAMPLE_WORDS == (32'd1 << AW));
  localparam int unsigned RW    = ((AW > mvsm_pkg::OP_W) ? AW : mvsm_pkg::OP_W) + 1;
  // A power of two is a plain mask; a modulus above the operand range needs no step.
  localparam int unsigned STEPS = (POW2 || (AW > mvsm_pkg::OP_W)) ? 0
                                  : (mvsm_pkg::OP_W + 1 - AW);
  localparam int unsigned CW    = (STEPS > 0) ? $clog2(STEPS + 1) : 1;
  localparam logic [RW-1:0] MODULUS = RW'(SAMPLE_WORDS);

  logic [RW-1:0] rem_q;
  logic [CW-1:0] cnt_q;
  logic          run_q;
  logic [RW-1:0] sub_step;

  assign sub_step = MODULUS << (cnt_q - CW'(1));
  assign done_o   = run_q && (cnt_q == '0);
  assign addr_o   = rem_q[AW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= 1'b0;
      cnt_q <= '0;
    end else if (start_i) begin
      run_q <= 1'b1;
      cnt_q <= CW'(STEPS);
    end else if (cnt_q != '0) begin
      cnt_q <= cnt_q - CW'(1);
    end else if (done_o) begin
      run_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= RW'(operand_i);
    end else if ((cnt_q != '0) && (rem_q >= sub_step)) begin
      rem_q <= rem_q - sub_step;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/mvsm_sample_ram.sv =====
// Sample memory of the mixer: one write port and one read port with a
// registered read word. Depends on mvsm_pkg for the sample type.
`default_nettype none

module mvsm_sample_ram #(
  parameter int unsigned DEPTH = 65536
) (
  input  wire logic                      clk_i,
  input  wire logic                      wr_en_i,
  input  wire logic [$clog2(DEPTH)-1:0]  wr_addr_i,
  input  wire mvsm_pkg::sample_t         wr_data_i,
  input  wire logic                      rd_en_i,
  input  wire logic [$clog2(DEPTH)-1:0]  rd_addr_i,
  output mvsm_pkg::sample_t              rd_data_o
);

  mvsm_pkg::sample_t mem_q [DEPTH];
  mvsm_pkg::sample_t rd_data_q;

  assign rd_data_o = rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // The read word holds until the next read so the sequencer may pick it up late.
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/mvsm_out_scale.sv =====
// Output stage of the mixer: clamps a voice sum to +/-32768 and scales it by
// 32767/32768 with truncation toward zero. Depends on mvsm_pkg.
`default_nettype none

module mvsm_out_scale #(
  parameter int unsigned ACC_W = 20
) (
  input  wire logic signed [ACC_W-1:0] sum_i,
  output mvsm_pkg::sample_t            sample_o
);

  localparam logic signed [ACC_W-1:0] POS_LIM = ACC_W'(32768);
  localparam logic signed [ACC_W-1:0] NEG_LIM = -POS_LIM;

  logic signed [ACC_W-1:0] clamped;
  logic signed [ACC_W-1:0] scaled;

  // Within the clamp range, trunc(s * 32767 / 32768) is s moved one step toward zero.
  always_comb begin
    clamped = sum_i;
    if (sum_i > POS_LIM) begin
      clamped = POS_LIM;
    end else if (sum_i < NEG_LIM) begin
      clamped = NEG_LIM;
    end
    if (clamped > 0) begin
      scaled = ACC_W'(clamped - 1);
    end else if (clamped < 0) begin
      scaled = ACC_W'(clamped + 1);
    end else begin
      scaled = '0;
    end
  end

  assign sample_o = scaled[mvsm_pkg::SAMPLE_W-1:0];

endmodule

`default_nettype wire
